>>> design/pcwc_pkg.sv
// Shared types, widths and helpers for the portal column window clip block.
// No dependencies; imported by every other file of the block.
package pcwc_pkg;

  // Field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned COL_W  = 9;
  localparam int unsigned ROW_W  = 12;
  localparam int unsigned FIX_W  = 32;
  localparam int unsigned FRAC_W = 16;
  // Rounded line row: enough bits for the whole 16.16 integer part plus carry
  localparam int unsigned RND_W  = FIX_W + 1 - FRAC_W;
  // Column compare width, covers the largest screen width
  localparam int unsigned IDX_W  = 13;

  localparam int unsigned SCREEN_WIDTH_DEF = 512;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  // Words that can be in flight: queue, one in the back end, output register
  localparam int unsigned MAX_INFLIGHT = QUEUE_DEPTH + 2;

  // Operation codes on the input port
  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_EDGE = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  // Classified work for the back end
  typedef enum logic [1:0] {
    K_NOP,
    K_LOAD,
    K_EDGE,
    K_READ
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] top;
    logic [ROW_W-1:0] bottom;
    logic [COL_W-1:0] last;
    logic [FIX_W-1:0] ceil_y;
    logic [FIX_W-1:0] ceil_d;
    logic [FIX_W-1:0] floor_y;
    logic [FIX_W-1:0] floor_d;
  } cmd_t;

  // Round a 16.16 line to the nearest row, ties upward
  function automatic logic signed [RND_W-1:0] round_line(input logic [FIX_W-1:0] y);
    logic signed [FIX_W:0] sum;
    sum = $signed({y[FIX_W-1], y}) + $signed((FIX_W+1)'(1 << (FRAC_W - 1)));
    return sum[FIX_W:FRAC_W];
  endfunction

endpackage

>>> design/pcwc_front.sv
// Front end: decodes and classifies each input word into a back-end command.
// Depends on pcwc_pkg.
module pcwc_front #(
  parameter int unsigned SCREEN_WIDTH = pcwc_pkg::SCREEN_WIDTH_DEF
) (
  input  logic                                in_valid_i,
  input  logic [pcwc_pkg::OP_W-1:0]           operation_i,
  input  logic [pcwc_pkg::COL_W-1:0]          column_i,
  input  logic signed [pcwc_pkg::ROW_W-1:0]   window_top_i,
  input  logic signed [pcwc_pkg::ROW_W-1:0]   window_bottom_i,
  input  logic [pcwc_pkg::COL_W-1:0]          edge_last_column_i,
  input  logic signed [pcwc_pkg::FIX_W-1:0]   ceiling_start_i,
  input  logic signed [pcwc_pkg::FIX_W-1:0]   ceiling_slope_i,
  input  logic signed [pcwc_pkg::FIX_W-1:0]   floor_start_i,
  input  logic signed [pcwc_pkg::FIX_W-1:0]   floor_slope_i,
  output logic                                push_o,
  output pcwc_pkg::cmd_t                      cmd_o
);
  import pcwc_pkg::*;

  logic col_in_range;
  op_e  op;

  assign op           = op_e'(operation_i);
  assign col_in_range = IDX_W'(column_i) < IDX_W'(SCREEN_WIDTH);
  assign push_o       = in_valid_i;

  // Classify: out-of-range loads/reads, reversed edges and the unused code do nothing
  always_comb begin
    cmd_o.column  = column_i;
    cmd_o.top     = window_top_i;
    cmd_o.bottom  = window_bottom_i;
    cmd_o.last    = edge_last_column_i;
    cmd_o.ceil_y  = ceiling_start_i;
    cmd_o.ceil_d  = ceiling_slope_i;
    cmd_o.floor_y = floor_start_i;
    cmd_o.floor_d = floor_slope_i;
    case (op)
      OP_LOAD: cmd_o.kind = col_in_range ? K_LOAD : K_NOP;
      OP_EDGE: cmd_o.kind = (edge_last_column_i >= column_i) ? K_EDGE : K_NOP;
      OP_READ: cmd_o.kind = col_in_range ? K_READ : K_NOP;
      default: cmd_o.kind = K_NOP;
    endcase
  end

endmodule

>>> design/pcwc_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on pcwc_pkg (cmd_t, QUEUE_DEPTH).
module pcwc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pcwc_pkg::cmd_t cmd_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output pcwc_pkg::cmd_t cmd_o
);
  import pcwc_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign cmd_o   = entry_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= cmd_i;
  end

endmodule

>>> design/pcwc_back.sv
// Back end: window memories, edge column walker and the output register.
// Depends on pcwc_pkg (cmd_t, kind_e, round_line, widths).
module pcwc_back #(
  parameter int unsigned SCREEN_WIDTH = pcwc_pkg::SCREEN_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  pcwc_pkg::cmd_t                    q_cmd_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [pcwc_pkg::ROW_W-1:0] child_top_o,
  output logic signed [pcwc_pkg::ROW_W-1:0] child_bottom_o
);
  import pcwc_pkg::*;

  localparam int unsigned AW = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
  localparam int unsigned MW = 2 * ROW_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EDGE,
    S_TAIL,
    S_DONE
  } state_e;

  function automatic logic [AW-1:0] to_addr(input logic [COL_W-1:0] col);
    logic [IDX_W-1:0] ext;
    ext = IDX_W'(col);
    return ext[AW-1:0];
  endfunction

  function automatic logic in_range(input logic [COL_W-1:0] col);
    return IDX_W'(col) < IDX_W'(SCREEN_WIDTH);
  endfunction

  // Memories: {top, bottom} per column
  logic [MW-1:0] par_mem [SCREEN_WIDTH];
  logic [MW-1:0] chl_mem [SCREEN_WIDTH];
  logic [MW-1:0] par_rd_q, chl_rd_q;

  state_e                  state_q;
  logic [COL_W-1:0]        x_q, last_q;
  logic [FIX_W-1:0]        ceil_q, ceil_d_q, floor_q, floor_d_q;
  logic signed [RND_W-1:0] rc_q, rf_q;
  logic                    p1_valid_q;
  logic [AW-1:0]           p1_addr_q;
  logic                    res_read_q;
  logic                    out_valid_q;
  logic [ROW_W-1:0]        out_top_q, out_bot_q;

  logic          pop_load, pop_read, out_free;
  logic          rd_en, par_we, chl_we;
  logic [AW-1:0] rd_addr, chl_waddr;
  logic [MW-1:0] chl_wdata;

  // Column update operands
  logic signed [RND_W-1:0] ptop_x, pbot_x, cbot_x;
  logic [ROW_W-1:0]        new_ctop, new_cbot;

  assign q_pop_o        = (state_q == S_IDLE) && q_valid_i;
  assign pop_load       = q_pop_o && (q_cmd_i.kind == K_LOAD);
  assign pop_read       = q_pop_o && (q_cmd_i.kind == K_READ);
  assign out_free       = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign child_top_o    = out_top_q;
  assign child_bottom_o = out_bot_q;

  // Clip step for the column read in the previous cycle
  always_comb begin
    ptop_x = RND_W'($signed(par_rd_q[MW-1:ROW_W]));
    pbot_x = RND_W'($signed(par_rd_q[ROW_W-1:0]));
    cbot_x = RND_W'($signed(chl_rd_q[ROW_W-1:0]));
    new_ctop = chl_rd_q[MW-1:ROW_W];
    new_cbot = chl_rd_q[ROW_W-1:0];
    // ceiling raises the top, at most to the child bottom + 1
    if (rc_q > ptop_x) begin
      new_ctop = (rc_q <= cbot_x) ? rc_q[ROW_W-1:0] : chl_rd_q[ROW_W-1:0] + 1'b1;
    end
    // floor lowers the bottom, at least to the parent top - 1
    if (rf_q < pbot_x) begin
      new_cbot = (rf_q >= ptop_x) ? rf_q[ROW_W-1:0] : par_rd_q[MW-1:ROW_W] - 1'b1;
    end
  end

  // Memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = to_addr(x_q);
    if (pop_read) begin
      rd_en   = 1'b1;
      rd_addr = to_addr(q_cmd_i.column);
    end else if (state_q == S_EDGE && in_range(x_q)) begin
      rd_en = 1'b1;
    end
    par_we    = pop_load;
    chl_we    = pop_load || p1_valid_q;
    chl_waddr = p1_valid_q ? p1_addr_q : to_addr(q_cmd_i.column);
    chl_wdata = p1_valid_q ? {new_ctop, new_cbot} : {q_cmd_i.top, q_cmd_i.bottom};
  end

  // Parent window memory
  always_ff @(posedge clk_i) begin
    if (par_we) par_mem[to_addr(q_cmd_i.column)] <= {q_cmd_i.top, q_cmd_i.bottom};
    if (rd_en)  par_rd_q <= par_mem[rd_addr];
  end

  // Child window memory
  always_ff @(posedge clk_i) begin
    if (chl_we) chl_mem[chl_waddr] <= chl_wdata;
    if (rd_en)  chl_rd_q <= chl_mem[rd_addr];
  end

  // Sequencer, line accumulators and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      x_q         <= '0;
      last_q      <= '0;
      ceil_q      <= '0;
      ceil_d_q    <= '0;
      floor_q     <= '0;
      floor_d_q   <= '0;
      rc_q        <= '0;
      rf_q        <= '0;
      p1_valid_q  <= 1'b0;
      p1_addr_q   <= '0;
      res_read_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_top_q   <= '0;
      out_bot_q   <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      p1_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            res_read_q <= q_cmd_i.kind == K_READ;
            if (q_cmd_i.kind == K_EDGE) begin
              x_q       <= q_cmd_i.column;
              last_q    <= q_cmd_i.last;
              ceil_q    <= q_cmd_i.ceil_y;
              ceil_d_q  <= q_cmd_i.ceil_d;
              floor_q   <= q_cmd_i.floor_y;
              floor_d_q <= q_cmd_i.floor_d;
              state_q   <= S_EDGE;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        // one column per cycle; lines step even past the screen edge
        S_EDGE: begin
          p1_valid_q <= in_range(x_q);
          p1_addr_q  <= to_addr(x_q);
          rc_q       <= round_line(ceil_q);
          rf_q       <= round_line(floor_q);
          ceil_q     <= ceil_q + ceil_d_q;
          floor_q    <= floor_q + floor_d_q;
          x_q        <= x_q + 1'b1;
          if (x_q == last_q) state_q <= S_TAIL;
        end
        // last column writes back this cycle
        S_TAIL: state_q <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_top_q   <= res_read_q ? chl_rd_q[MW-1:ROW_W] : '0;
            out_bot_q   <= res_read_q ? chl_rd_q[ROW_W-1:0] : '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/portal_column_window_clip.sv
// Top level of the portal column window clip block.
// Depends on pcwc_pkg, pcwc_front, pcwc_queue and pcwc_back.
//
//   channel | direction | handshake                 | word
//   --------+-----------+---------------------------+------------------------------
//   in      | sink      | in_valid_i / in_stall_o   | operation, column, windows,
//           |           |                           | edge last column, two lines
//   out     | source    | out_valid_o / out_stall_i | child_top, child_bottom
//
// Every input word yields exactly one output word (zeros unless a read).
// Load, read and no-op go from idle straight to the done state; an edge walks the window
// memories one column read and one write per cycle, then passes a tail state before done.
// The queue holds two words, so the front keeps accepting while the back works.
// Reset is asynchronous active low; memories come up undefined until loaded.
// in_stall_o rises only when the queue is full; a stalled output word holds.
module portal_column_window_clip #(
  parameter int unsigned SCREEN_WIDTH = pcwc_pkg::SCREEN_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [pcwc_pkg::OP_W-1:0]         operation_i,
  input  logic [pcwc_pkg::COL_W-1:0]        column_i,
  input  logic signed [pcwc_pkg::ROW_W-1:0] window_top_i,
  input  logic signed [pcwc_pkg::ROW_W-1:0] window_bottom_i,
  input  logic [pcwc_pkg::COL_W-1:0]        edge_last_column_i,
  input  logic signed [pcwc_pkg::FIX_W-1:0] ceiling_start_i,
  input  logic signed [pcwc_pkg::FIX_W-1:0] ceiling_slope_i,
  input  logic signed [pcwc_pkg::FIX_W-1:0] floor_start_i,
  input  logic signed [pcwc_pkg::FIX_W-1:0] floor_slope_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [pcwc_pkg::ROW_W-1:0] child_top_o,
  output logic signed [pcwc_pkg::ROW_W-1:0] child_bottom_o
);
  import pcwc_pkg::*;

  logic push, q_full, q_valid, q_pop;
  cmd_t front_cmd, q_cmd;

  assign in_stall_o = q_full;

  // Decode and classify
  pcwc_front #(
    .SCREEN_WIDTH(SCREEN_WIDTH)
  ) u_front (
    .in_valid_i        (in_valid_i),
    .operation_i       (operation_i),
    .column_i          (column_i),
    .window_top_i      (window_top_i),
    .window_bottom_i   (window_bottom_i),
    .edge_last_column_i(edge_last_column_i),
    .ceiling_start_i   (ceiling_start_i),
    .ceiling_slope_i   (ceiling_slope_i),
    .floor_start_i     (floor_start_i),
    .floor_slope_i     (floor_slope_i),
    .push_o            (push),
    .cmd_o             (front_cmd)
  );

  // Command queue
  pcwc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .cmd_o  (q_cmd)
  );

  // Execute against the window memories
  pcwc_back #(
    .SCREEN_WIDTH(SCREEN_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_cmd_i       (q_cmd),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .child_top_o   (child_top_o),
    .child_bottom_o(child_bottom_o)
  );

endmodule

>>> design/pcwc_checker.sv
// Port-level checker for portal_column_window_clip, attached by bind.
// Depends on pcwc_pkg (MAX_INFLIGHT, ROW_W).
module pcwc_sva_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [pcwc_pkg::ROW_W-1:0] child_top_o,
  input logic signed [pcwc_pkg::ROW_W-1:0] child_bottom_o
);
  import pcwc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_INFLIGHT + 1) + 1;

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] inflight_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Words accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_q <= inflight_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      inflight_q <= inflight_q - 1'b1;
    end
  end

  // Output word holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(child_top_o) && $stable(child_bottom_o))
    else $error("output word changed while stalled");

  // No result without an outstanding input word
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != '0)
    else $error("output word without an accepted input word");

  // Queue plus back end bound the words in flight
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CNT_W'(MAX_INFLIGHT))
    else $error("more words in flight than the block can hold");

endmodule

bind portal_column_window_clip pcwc_sva_checker u_pcwc_sva_checker (.*);

>>> dv/pcwc_checker.sv
`timescale 1ns / 1ps
// Scoreboard for portal_column_window_clip: watches both channels, predicts each child
// window word from its own copy of the clip windows and counts mismatches. Uses pcwc_pkg.
module pcwc_checker #(
  parameter int unsigned COLS = 512
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [pcwc_pkg::OP_W-1:0]         operation_i,
  input  logic [pcwc_pkg::COL_W-1:0]        column_i,
  input  logic signed [pcwc_pkg::ROW_W-1:0] window_top_i,
  input  logic signed [pcwc_pkg::ROW_W-1:0] window_bottom_i,
  input  logic [pcwc_pkg::COL_W-1:0]        edge_last_column_i,
  input  logic signed [pcwc_pkg::FIX_W-1:0] ceiling_start_i,
  input  logic signed [pcwc_pkg::FIX_W-1:0] ceiling_slope_i,
  input  logic signed [pcwc_pkg::FIX_W-1:0] floor_start_i,
  input  logic signed [pcwc_pkg::FIX_W-1:0] floor_slope_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [pcwc_pkg::ROW_W-1:0] child_top_i,
  input  logic signed [pcwc_pkg::ROW_W-1:0] child_bottom_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o
);
  import pcwc_pkg::*;

  typedef struct packed {
    logic signed [ROW_W-1:0] top;
    logic signed [ROW_W-1:0] bottom;
  } child_row_t;

  // Private copy of the parent and child windows
  logic signed [ROW_W-1:0] par_top [COLS];
  logic signed [ROW_W-1:0] par_bot [COLS];
  logic signed [ROW_W-1:0] chd_top [COLS];
  logic signed [ROW_W-1:0] chd_bot [COLS];

  child_row_t child_rows_due[$];
  child_row_t head_row;

  // Nearest row of a 16.16 line, ties upward
  function automatic int round_row(input logic [FIX_W-1:0] y);
    longint biased;
    biased = longint'($signed(y)) + 64'sd32768;
    return int'(biased >>> 16);
  endfunction

  // Apply one accepted word to the window copy and queue the word it yields
  task automatic apply_clip_word();
    child_row_t       due;
    logic [FIX_W-1:0] ceil_y;
    logic [FIX_W-1:0] floor_y;
    int               rc;
    int               rf;
    int               pt;
    int               pb;
    int               cb;
    due     = '0;
    ceil_y  = ceiling_start_i;
    floor_y = floor_start_i;
    case (op_e'(operation_i))
      OP_LOAD: begin
        if (column_i < COLS) begin
          par_top[column_i] = window_top_i;
          par_bot[column_i] = window_bottom_i;
          chd_top[column_i] = window_top_i;
          chd_bot[column_i] = window_bottom_i;
        end
      end
      OP_EDGE: begin
        // reversed edge falls straight through the loop
        for (int x = int'(column_i); x <= int'(edge_last_column_i); x++) begin
          if (x < COLS) begin
            rc = round_row(ceil_y);
            rf = round_row(floor_y);
            pt = int'(par_top[x]);
            pb = int'(par_bot[x]);
            cb = int'(chd_bot[x]);   // ceiling sees the bottom before this column's floor
            if (rc > pt) chd_top[x] = (rc <= cb) ? ROW_W'(rc) : ROW_W'(cb + 1);
            if (rf < pb) chd_bot[x] = (rf >= pt) ? ROW_W'(rf) : ROW_W'(pt - 1);
          end
          ceil_y  = ceil_y + ceiling_slope_i;
          floor_y = floor_y + floor_slope_i;
        end
      end
      OP_READ: begin
        if (column_i < COLS) begin
          due.top    = chd_top[column_i];
          due.bottom = chd_bot[column_i];
        end
      end
      default: ;
    endcase
    child_rows_due.push_back(due);
  endtask

  // Predict on input acceptance, compare on output acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      child_rows_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && !in_stall_i) apply_clip_word();
      if (out_valid_i && !out_stall_i) begin
        if (child_rows_due.size() == 0) begin
          $error("child word with none pending: top %0d, bottom %0d",
                 child_top_i, child_bottom_i);
          fail_count_o++;
        end else begin
          head_row = child_rows_due.pop_front();
          if (child_top_i !== head_row.top) begin
            $error("child_top: expected %0d, actual %0d", head_row.top, child_top_i);
            fail_count_o++;
          end
          if (child_bottom_i !== head_row.bottom) begin
            $error("child_bottom: expected %0d, actual %0d", head_row.bottom, child_bottom_i);
            fail_count_o++;
          end
        end
      end
      pending_o = child_rows_due.size();
    end
  end

endmodule

>>> dv/portal_column_window_clip_tb.sv
`timescale 1ns / 1ps
// Testbench top for portal_column_window_clip: drives directed and random words with
// random idling on both sides and reports the verdict. Uses pcwc_pkg and pcwc_checker.
module portal_column_window_clip_tb;
  import pcwc_pkg::*;

  localparam int unsigned COLS         = 512;
  localparam int unsigned NUM_ITEMS    = 1400;
  localparam int unsigned QUIET_ITEMS  = 150;
  localparam int unsigned TAIL_CYCLES  = 32;
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;

  typedef struct {
    op_e              op;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] top;
    logic [ROW_W-1:0] bottom;
    logic [COL_W-1:0] last;
    logic [FIX_W-1:0] cy;
    logic [FIX_W-1:0] cd;
    logic [FIX_W-1:0] fy;
    logic [FIX_W-1:0] fd;
  } clip_word_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          operation = '0;
  logic [COL_W-1:0]         column = '0;
  logic signed [ROW_W-1:0]  window_top = '0;
  logic signed [ROW_W-1:0]  window_bottom = '0;
  logic [COL_W-1:0]         edge_last_column = '0;
  logic signed [FIX_W-1:0]  ceiling_start = '0;
  logic signed [FIX_W-1:0]  ceiling_slope = '0;
  logic signed [FIX_W-1:0]  floor_start = '0;
  logic signed [FIX_W-1:0]  floor_slope = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [ROW_W-1:0]  child_top;
  logic signed [ROW_W-1:0]  child_bottom;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned work_items = 0;
  int unsigned rx_hold = 0;
  int unsigned cycle_cnt = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  bit          drained_mid = 1'b0;
  bit          col_loaded [COLS];

  always #4 clk = ~clk;

  portal_column_window_clip i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .operation_i        (operation),
    .column_i           (column),
    .window_top_i       (window_top),
    .window_bottom_i    (window_bottom),
    .edge_last_column_i (edge_last_column),
    .ceiling_start_i    (ceiling_start),
    .ceiling_slope_i    (ceiling_slope),
    .floor_start_i      (floor_start),
    .floor_slope_i      (floor_slope),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .child_top_o        (child_top),
    .child_bottom_o     (child_bottom)
  );

  pcwc_checker #(.COLS(COLS)) i_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .operation_i        (operation),
    .column_i           (column),
    .window_top_i       (window_top),
    .window_bottom_i    (window_bottom),
    .edge_last_column_i (edge_last_column),
    .ceiling_start_i    (ceiling_start),
    .ceiling_slope_i    (ceiling_slope),
    .floor_start_i      (floor_start),
    .floor_slope_i      (floor_slope),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .child_top_i        (child_top),
    .child_bottom_i     (child_bottom),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  // Receiver stalls in random bursts
  always @(negedge clk) begin
    if (!rx_idle_en) begin
      rx_hold = 0;
      out_stall <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      rx_hold = $urandom_range(1, 13) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Word with every field random; callers then set what the operation uses
  function automatic clip_word_t random_word(input op_e op);
    clip_word_t w;
    w.op     = op;
    w.col    = COL_W'($urandom);
    w.top    = ROW_W'($urandom);
    w.bottom = ROW_W'($urandom);
    w.last   = COL_W'($urandom);
    w.cy     = $urandom;
    w.cd     = $urandom;
    w.fy     = $urandom;
    w.fd     = $urandom;
    return w;
  endfunction

  function automatic clip_word_t mk_load(input logic [COL_W-1:0] col,
                                         input logic [ROW_W-1:0] top,
                                         input logic [ROW_W-1:0] bottom);
    clip_word_t w;
    w = random_word(OP_LOAD);
    w.col    = col;
    w.top    = top;
    w.bottom = bottom;
    return w;
  endfunction

  function automatic clip_word_t mk_edge(input logic [COL_W-1:0] col,
                                         input logic [COL_W-1:0] last,
                                         input logic [FIX_W-1:0] cy, input logic [FIX_W-1:0] cd,
                                         input logic [FIX_W-1:0] fy, input logic [FIX_W-1:0] fd);
    clip_word_t w;
    w = random_word(OP_EDGE);
    w.col  = col;
    w.last = last;
    w.cy   = cy;
    w.cd   = cd;
    w.fy   = fy;
    w.fd   = fd;
    return w;
  endfunction

  function automatic clip_word_t mk_read(input logic [COL_W-1:0] col);
    clip_word_t w;
    w = random_word(OP_READ);
    w.col = col;
    return w;
  endfunction

  // Mostly rows around the screen, sometimes any 12-bit value
  function automatic logic [ROW_W-1:0] rand_row();
    if ($urandom_range(0, 9) == 0) return ROW_W'($urandom);
    return ROW_W'($urandom_range(0, 1025) - 1);
  endfunction

  // 16.16 line with its row in [lo, hi] and a random fraction, now and then any value
  function automatic logic [FIX_W-1:0] rand_line(input int lo, input int hi);
    int row;
    if ($urandom_range(0, 9) == 0) return $urandom;
    row = int'($urandom_range(0, hi - lo)) + lo;
    return {row[15:0], 16'($urandom)};
  endfunction

  // Slope of a few rows per column either way, flat, or any value
  function automatic logic [FIX_W-1:0] rand_slope();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return '0;
      default: return FIX_W'(int'($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000);
    endcase
  endfunction

  function automatic int pick_loaded_col();
    int c;
    do c = $urandom_range(0, COLS - 1); while (!col_loaded[c]);
    return c;
  endfunction

  function automatic clip_word_t rand_edge(input int a, input int b);
    return mk_edge(COL_W'(a), COL_W'(b), rand_line(-40, 700), rand_slope(),
                   rand_line(300, 1100), rand_slope());
  endfunction

  // One word over the input channel, with an optional gap before it
  task automatic send_word(input clip_word_t w);
    int unsigned gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    operation        <= w.op;
    column           <= w.col;
    window_top       <= w.top;
    window_bottom    <= w.bottom;
    edge_last_column <= w.last;
    ceiling_start    <= w.cy;
    ceiling_slope    <= w.cd;
    floor_start      <= w.fy;
    floor_slope      <= w.fd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (w.op == OP_LOAD) col_loaded[w.col] = 1'b1;
    if (w.op != OP_NONE && !(w.op == OP_EDGE && w.last < w.col)) work_items++;
    @(negedge clk);
  endtask

  // Hold the sender until every predicted word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending != 0);
  endtask

  // Extremes and special cases on a handful of columns
  task automatic run_directed();
    send_word(mk_load(9'd0, -12'sd1, 12'sd1024));
    send_word(mk_load(9'd1, 12'sd100, 12'sd200));
    send_word(mk_load(9'd2, 12'h800, 12'sd2047));
    send_word(mk_load(9'd3, 12'sd300, 12'sd2047));
    send_word(mk_load(9'd4, 12'sd0, 12'sd2047));
    send_word(mk_load(9'd510, 12'sd500, 12'sd400));   // window upside down
    send_word(mk_load(9'd511, 12'sd2047, 12'h800));
    send_word(mk_read(9'd0));
    send_word(mk_read(9'd511));
    // flat lines inside, and floor above the parent top
    send_word(mk_edge(9'd0, 9'd3, 32'(150 << 16), '0, 32'(180 << 16), '0));
    // ceiling below the child bottom: clamps to bottom plus one
    send_word(mk_edge(9'd1, 9'd1, 32'(1000 << 16), '0, 32'(2000 << 16), '0));
    // bottom plus one past the top row wraps
    send_word(mk_edge(9'd4, 9'd4, 32'(3000 << 16), '0, 32'(3000 << 16), '0));
    // parent top minus one past the lowest row wraps
    send_word(mk_edge(9'd2, 9'd2, 32'(-5000 * 65536), '0, 32'(-5000 * 65536), '0));
    // both accumulators wrap around 32 bits
    send_word(mk_edge(9'd0, 9'd1, 32'h7FFF_0000, 32'h0002_0000,
                      32'h8000_0000, 32'h7FFF_FFFF));
    // rounding ties, positive and negative, and just under a half
    send_word(mk_edge(9'd510, 9'd511, 32'h000A_8000, 32'hFFEB_0000,
                      32'h0014_7FFF, '0));
    // largest and smallest lines
    send_word(mk_edge(9'd3, 9'd3, 32'h7FFF_FFFF, '0, 32'h8000_0000, '0));
    send_word(mk_edge(9'd511, 9'd0, $urandom, $urandom, $urandom, $urandom));
    send_word(random_word(OP_NONE));
    for (int c = 0; c <= 4; c++) send_word(mk_read(COL_W'(c)));
    send_word(mk_read(9'd510));
    send_word(mk_read(9'd511));
  endtask

  // Load a run of columns, clip it with a few edges, read some back
  task automatic run_span();
    int               c;
    int               n;
    int               a;
    int               b;
    int               k;
    logic [ROW_W-1:0] t;
    logic [ROW_W-1:0] bt;
    logic [ROW_W-1:0] tmp;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 16);
    c = $urandom_range(0, COLS - 1);
    if (c + n > COLS) c = COLS - n;
    for (int i = 0; i < n; i++) begin
      t  = rand_row();
      bt = rand_row();
      if ($urandom_range(0, 7) != 0 && $signed(t) > $signed(bt)) begin
        tmp = t;
        t   = bt;
        bt  = tmp;
      end
      send_word(mk_load(COL_W'(c + i), t, bt));
    end
    k = $urandom_range(1, 4);
    repeat (k) begin
      if ($urandom_range(0, 3) == 0) begin
        a = c;
        b = c + n - 1;
      end else begin
        a = c + $urandom_range(0, n - 1);
        b = a + $urandom_range(0, c + n - 1 - a);
      end
      send_word(rand_edge(a, b));
    end
    k = (n < 6) ? $urandom_range(1, n) : $urandom_range(1, 6);
    repeat (k) send_word(mk_read(COL_W'(c + $urandom_range(0, n - 1))));
  endtask

  // Edge over a stretch of already loaded columns, sometimes a long one
  task automatic run_global_edge();
    int a;
    int b;
    int lim;
    a   = pick_loaded_col();
    lim = ($urandom_range(0, 24) == 0) ? COLS - 1 : $urandom_range(0, 30);
    b   = a;
    while (b < COLS - 1 && b - a < lim && col_loaded[b + 1]) b++;
    send_word(rand_edge(a, b));
    send_word(mk_read(COL_W'($urandom_range(a, b))));
  endtask

  // Unused operation, reversed edges and stray reads
  task automatic run_noise();
    int c;
    case ($urandom_range(0, 2))
      0: send_word(random_word(OP_NONE));
      1: begin
        c = $urandom_range(1, COLS - 1);
        send_word(mk_edge(COL_W'(c), COL_W'($urandom_range(0, c - 1)),
                          $urandom, $urandom, $urandom, $urandom));
      end
      default: send_word(mk_read(COL_W'(pick_loaded_col())));
    endcase
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    wait_drained();

    while (work_items < NUM_ITEMS) begin
      if (work_items + QUIET_ITEMS >= NUM_ITEMS) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: run_span();
        6, 7:             run_global_edge();
        8:                run_noise();
        default:          repeat ($urandom_range(1, 4)) send_word(mk_read(COL_W'(pick_loaded_col())));
      endcase
      if (!drained_mid && work_items >= NUM_ITEMS / 2) begin
        drained_mid = 1'b1;
        wait_drained();
      end
    end

    // Let the last words come back
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/pcwc_pkg.sv
design/pcwc_front.sv
design/pcwc_queue.sv
design/pcwc_back.sv
design/portal_column_window_clip.sv
design/pcwc_checker.sv
dv/pcwc_checker.sv
dv/portal_column_window_clip_tb.sv
